/* rtl/core/frc_pkg.sv */
// frc_pkg: item types, character codes and register constants for the
// fixed-point radix converter; used by every file in rtl/core
`timescale 1ns / 1ps
`default_nettype none

package frc_pkg;

    localparam int RADIX_W  = 5;
    localparam int DIGIT_W  = 4;
    localparam int CHAR_W   = 7;
    localparam int DIV_STEPS = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    // register index taken from paddr[2]
    localparam logic REG_RADIX = 1'b0;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 7'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;

    typedef struct packed {
        logic        negative;
        logic [30:0] integer_part;
        logic [31:0] fraction_part;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } out_item_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [DIGIT_W-1:0] digit);
        logic [CHAR_W-1:0] ch;
        if (digit < 4'd10) begin
            ch = CHAR_ZERO + CHAR_W'(digit);
        end else begin
            ch = CHAR_UPPER_A + CHAR_W'(digit - 4'd10);
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/frc_div.sv */
// frc_div: iterative divider of an unsigned integer by a radix of 2 to 16,
// eight quotient bits per cycle; depends on frc_pkg
`timescale 1ns / 1ps
`default_nettype none

module frc_div #(
    parameter int DIVIDEND_W = 31
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  wire [DIVIDEND_W-1:0]         dividend,
    input  wire [frc_pkg::RADIX_W-1:0]   divisor,
    output logic                         done,
    output logic [DIVIDEND_W-1:0]        quotient,
    output logic [frc_pkg::DIGIT_W-1:0]  remainder
);
    import frc_pkg::*;

    localparam int NCYC = (DIVIDEND_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int PW   = NCYC * DIV_STEPS;
    localparam int CW   = $clog2(NCYC + 1);

    logic [PW-1:0]      shreg_reg;
    logic [DIGIT_W-1:0] rem_reg;
    logic [RADIX_W-1:0] divisor_reg;
    logic [CW-1:0]      cyc_reg;
    logic               run_reg;
    logic               done_reg;

    logic [PW-1:0]      sh_next;
    logic [DIGIT_W-1:0] rem_next;
    logic [RADIX_W-1:0] trial;

    // eight restoring steps on the narrow remainder
    always_comb begin
        sh_next  = shreg_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIV_STEPS; i++) begin
            trial   = {rem_next, sh_next[PW-1]};
            sh_next = {sh_next[PW-2:0], 1'b0};
            if (trial >= divisor_reg) begin
                rem_next   = DIGIT_W'(trial - divisor_reg);
                sh_next[0] = 1'b1;
            end else begin
                rem_next = trial[DIGIT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cyc_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                shreg_reg   <= PW'(dividend);
                rem_reg     <= '0;
                divisor_reg <= divisor;
                cyc_reg     <= '0;
                run_reg     <= 1'b1;
            end else if (run_reg) begin
                shreg_reg <= sh_next;
                rem_reg   <= rem_next;
                cyc_reg   <= cyc_reg + 1'b1;
                if (cyc_reg == CW'(NCYC - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = DIVIDEND_W'(shreg_reg);
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* rtl/core/fixed_point_radix_converter_top.sv */
// fixed_point_radix_converter_top: sequencer, digit store, fraction multiplier
// and APB radix register; depends on frc_pkg and frc_div
// flow: each integer digit comes from the shared divider (ST_DIV_GO, ST_DIV_WAIT) and goes
// out through ST_RD and ST_INT; sign, point and fraction characters leave from their own states
// one item at a time: a new number is accepted only in ST_IDLE, once the last character of
// the previous one is loaded; output stalls hold every character state
// reset: synchronous active-low, radix returns to 10, output register empties
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_radix_converter_top #(
    parameter int FRAC_DIGITS = 10,
    parameter int INT_WIDTH   = 31,
    parameter int FRAC_WIDTH  = 32
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  frc_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output frc_pkg::out_item_t  m_data,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [2:0]           paddr,
    input  wire [31:0]          pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import frc_pkg::*;

    localparam int IW   = $clog2(INT_WIDTH);
    localparam int CNTW = $clog2(INT_WIDTH + 1);
    localparam int FDW  = $clog2(FRAC_DIGITS + 1);
    localparam int PRW  = FRAC_WIDTH + RADIX_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIGN,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_RD,
        ST_INT,
        ST_DOT,
        ST_FRAC,
        ST_DOT2
    } state_t;

    state_t                state_reg;
    logic [RADIX_W-1:0]    radix_reg;
    logic [RADIX_W-1:0]    base_reg;
    logic [INT_WIDTH-1:0]  q_reg;
    logic [FRAC_WIDTH-1:0] f_reg;
    logic [CNTW-1:0]       cnt_reg;
    logic [IW-1:0]         idx_reg;
    logic [FDW-1:0]        fd_reg;
    logic [DIGIT_W-1:0]    rdata_reg;
    logic                  out_valid_reg;
    out_item_t             out_item_reg;

    logic [DIGIT_W-1:0]    digit_store [INT_WIDTH];

    logic                  can_load;
    logic                  div_done;
    logic [INT_WIDTH-1:0]  div_quot;
    logic [DIGIT_W-1:0]    div_rem;
    logic [PRW-1:0]        prod;
    logic [FRAC_WIDTH-1:0] f_new;
    logic [DIGIT_W-1:0]    f_digit;
    logic                  cfg_wr;

    frc_div #(
        .DIVIDEND_W(INT_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (state_reg == ST_DIV_GO),
        .dividend  (q_reg),
        .divisor   (base_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign can_load = !out_valid_reg || m_ready;
    assign prod     = PRW'(f_reg) * PRW'(base_reg);
    assign f_new    = prod[FRAC_WIDTH-1:0];
    assign f_digit  = prod[FRAC_WIDTH+DIGIT_W-1:FRAC_WIDTH];
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_RADIX);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_RADIX) ? 32'(radix_reg) : '0;

    // digit store, least significant digit first
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIV_WAIT && div_done && cnt_reg < CNTW'(INT_WIDTH)) begin
            digit_store[cnt_reg[IW-1:0]] <= div_rem;
        end
        if (state_reg == ST_RD) begin
            rdata_reg <= digit_store[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            radix_reg     <= RADIX_RESET;
            base_reg      <= RADIX_RESET;
            q_reg         <= '0;
            f_reg         <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            fd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr) begin
                radix_reg <= pwdata[RADIX_W-1:0];
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        q_reg   <= INT_WIDTH'(s_data.integer_part);
                        f_reg   <= FRAC_WIDTH'(s_data.fraction_part);
                        cnt_reg <= '0;
                        if (radix_reg < RADIX_MIN) begin
                            base_reg <= RADIX_MIN;
                        end else if (radix_reg > RADIX_MAX) begin
                            base_reg <= RADIX_MAX;
                        end else begin
                            base_reg <= radix_reg;
                        end
                        state_reg <= s_data.negative ? ST_SIGN : ST_DIV_GO;
                    end
                end
                ST_SIGN: begin
                    if (can_load) begin
                        out_valid_reg          <= 1'b1;
                        out_item_reg.character <= CHAR_MINUS;
                        out_item_reg.last      <= 1'b0;
                        state_reg              <= ST_DIV_GO;
                    end
                end
                ST_DIV_GO: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        q_reg <= div_quot;
                        if (cnt_reg < CNTW'(INT_WIDTH)) begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        if (div_quot == '0) begin
                            idx_reg   <= cnt_reg[IW-1:0];
                            state_reg <= ST_RD;
                        end else begin
                            state_reg <= ST_DIV_GO;
                        end
                    end
                end
                ST_RD: begin
                    state_reg <= ST_INT;
                end
                ST_INT: begin
                    if (can_load) begin
                        out_valid_reg          <= 1'b1;
                        out_item_reg.character <= hex_char(rdata_reg);
                        out_item_reg.last      <= (idx_reg == '0) && (f_reg == '0);
                        if (idx_reg == '0) begin
                            state_reg <= (f_reg == '0) ? ST_IDLE : ST_DOT;
                        end else begin
                            idx_reg   <= idx_reg - 1'b1;
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_DOT: begin
                    if (can_load) begin
                        out_valid_reg          <= 1'b1;
                        out_item_reg.character <= CHAR_DOT;
                        out_item_reg.last      <= 1'b0;
                        fd_reg                 <= '0;
                        state_reg              <= ST_FRAC;
                    end
                end
                ST_FRAC: begin
                    if (can_load) begin
                        out_valid_reg <= 1'b1;
                        if (fd_reg == FDW'(FRAC_DIGITS)) begin
                            out_item_reg.character <= CHAR_DOT;
                            out_item_reg.last      <= 1'b0;
                            state_reg              <= ST_DOT2;
                        end else begin
                            out_item_reg.character <= hex_char(f_digit);
                            out_item_reg.last      <= (f_new == '0);
                            f_reg                  <= f_new;
                            fd_reg                 <= fd_reg + 1'b1;
                            if (f_new == '0) begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                end
                ST_DOT2: begin
                    if (can_load) begin
                        out_valid_reg          <= 1'b1;
                        out_item_reg.character <= CHAR_DOT;
                        out_item_reg.last      <= 1'b1;
                        state_reg              <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNTW'(INT_WIDTH))
        else $error("integer digit count beyond store depth");

    a_base_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (base_reg >= RADIX_MIN && base_reg <= RADIX_MAX))
        else $error("working radix out of range");

    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside wait state");

    a_frac_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fd_reg <= FDW'(FRAC_DIGITS))
        else $error("fraction digit count beyond limit");
`endif

endmodule

`default_nettype wire

/* tb/tb.sv */
// tb: checks fixed_point_radix_converter_top against a scoreboard that spells each number
// in the current radix; random bursts, stalls and radix changes; depends on frc_pkg
`timescale 1ns / 1ps

module tb;
    import frc_pkg::*;

    localparam int FRACTION_LIMIT = 10;
    localparam int MAX_TEXT       = 45;
    localparam int SETTLE_CYCLES  = 40;

    class numeral_scoreboard;
        out_item_t           expected_text[$];
        logic [RADIX_W-1:0]  radix;
        int                  mismatches;
        string               glyphs;

        function new();
            radix = RADIX_RESET;
            mismatches = 0;
            glyphs = "0123456789ABCDEF";
        endfunction

        function int pending();
            return expected_text.size();
        endfunction

        // spell one accepted number and queue its characters
        function void note_number(in_item_t item);
            logic [RADIX_W-1:0] base;
            logic [31:0]        quotient;
            logic [31:0]        fraction;
            logic [63:0]        product;
            logic [3:0]         int_digits[31];
            logic [CHAR_W-1:0]  text[MAX_TEXT];
            int                 count;
            int                 n;
            int                 placed;
            out_item_t          entry;
            base = radix;
            if (base < RADIX_MIN) begin
                base = RADIX_MIN;
            end
            if (base > RADIX_MAX) begin
                base = RADIX_MAX;
            end
            quotient = {1'b0, item.integer_part};
            fraction = item.fraction_part;
            n = 0;
            if (item.negative) begin
                text[n] = CHAR_MINUS;
                n++;
            end
            count = 0;
            do begin
                int_digits[count] = 4'(quotient % base);
                count++;
                quotient = quotient / base;
            end while (quotient != 0);
            for (int k = count - 1; k >= 0; k--) begin
                text[n] = CHAR_W'(glyphs[int_digits[k]]);
                n++;
            end
            if (fraction != 0) begin
                text[n] = CHAR_DOT;
                n++;
                placed = 0;
                while (fraction != 0) begin
                    if (placed == FRACTION_LIMIT) begin
                        text[n] = CHAR_DOT;
                        text[n + 1] = CHAR_DOT;
                        n += 2;
                        break;
                    end
                    product = {32'b0, fraction} * base;
                    text[n] = CHAR_W'(glyphs[product[35:32]]);
                    n++;
                    fraction = product[31:0];
                    placed++;
                end
            end
            for (int k = 0; k < n; k++) begin
                entry.character = text[k];
                entry.last = (k == n - 1);
                expected_text.push_back(entry);
            end
        endfunction

        function void check_char(out_item_t got);
            out_item_t want;
            if (expected_text.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("tb: unexpected item char=%h last=%b", got.character, got.last);
                end
            end else begin
                want = expected_text.pop_front();
                if (got.character !== want.character || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("tb: mismatch char exp=%h got=%h last exp=%b got=%b",
                                 want.character, got.character, want.last, got.last);
                    end
                end
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    numeral_scoreboard sb = new();

    int   stall_mode = 0;
    int   stall_left = 0;
    logic [1:0] stall_phase = '0;
    int   burst_left = 0;
    bit   gaps_on = 1'b1;

    fixed_point_radix_converter_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    // receiver stall pattern, picks a new random mode when its countdown runs out
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            stall_phase <= stall_phase + 2'd1;
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                stall_left <= $urandom_range(20, 200);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_ready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_ready <= (stall_phase != 2'd0);
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_char(m_data);
        end
    end

    initial begin
        #(10_000_000);
        $display("tb: failure");
        $finish;
    end

    task automatic send_number(in_item_t item);
        s_data <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_number(item);
        if (gaps_on) begin
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst_left = $urandom_range(1, 8);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic write_radix(logic [RADIX_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_RADIX, 2'b00};
        pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.radix = value;
    endtask

    function automatic in_item_t random_number();
        in_item_t item;
        item.negative = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: item.integer_part = '0;
            1: item.integer_part = 31'($urandom_range(0, 40));
            2: item.integer_part = 31'h7FFF_FFFF;
            3, 4: item.integer_part = 31'($urandom >> $urandom_range(0, 31));
            default: item.integer_part = 31'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0: item.fraction_part = '0;
            1: item.fraction_part = 32'hFFFF_FFFF;
            2: item.fraction_part = $urandom & ~(32'hFFFF_FFFF >> $urandom_range(1, 12));
            3: item.fraction_part = 32'h1 << $urandom_range(0, 31);
            default: item.fraction_part = $urandom;
        endcase
        return item;
    endfunction

    initial begin
        in_item_t directed[12];
        in_item_t edges[3];
        logic [RADIX_W-1:0] phase_radix[9];
        directed = '{
            '{1'b0, 31'd0, 32'h0000_0000},
            '{1'b1, 31'd0, 32'h0000_0000},
            '{1'b0, 31'h7FFF_FFFF, 32'h0000_0000},
            '{1'b1, 31'h7FFF_FFFF, 32'hFFFF_FFFF},
            '{1'b0, 31'd0, 32'h8000_0000},
            '{1'b0, 31'd0, 32'h0040_0000},
            '{1'b1, 31'd0, 32'h0020_0000},
            '{1'b0, 31'd0, 32'h0000_0001},
            '{1'b1, 31'd12345, 32'h4000_0000},
            '{1'b0, 31'd1, 32'h0000_0000},
            '{1'b0, 31'd10, 32'h0000_0000},
            '{1'b0, 31'd9, 32'hFFFF_FFFF}
        };
        edges = '{
            '{1'b0, 31'h7FFF_FFFF, 32'hFFFF_FFFF},
            '{1'b1, 31'd0, 32'h0040_0000},
            '{1'b0, 31'd0, 32'h0000_0000}
        };
        // extremes, out-of-range values that clamp, then ordinary bases
        phase_radix = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd17, 5'd1, 5'd3, 5'd7, 5'd10};
        phase_radix[8] = 5'($urandom_range(4, 15));
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        burst_left = $urandom_range(1, 8);
        foreach (directed[i]) begin
            send_number(directed[i]);
        end
        for (int ph = 0; ph < 9; ph++) begin
            drain();
            write_radix(phase_radix[ph]);
            gaps_on = (ph != 3);
            foreach (edges[i]) begin
                send_number(edges[i]);
            end
            for (int i = 0; i < 27; i++) begin
                if (ph == 1 && i == 15) begin
                    drain();
                end
                send_number(random_number());
            end
        end
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/frc_pkg.sv
rtl/core/frc_div.sv
rtl/core/fixed_point_radix_converter_top.sv
tb/tb.sv
